/* sv/cmab_pkg.sv */
`default_nettype none
package cmab_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int PADDR_WIDTH = 5;
    localparam int PDATA_WIDTH = 32;
    localparam int REG_IDX_WIDTH = 3;

    localparam logic [COORD_WIDTH-1:0] CLIP_RB_RESET = COORD_WIDTH'(2048);

    localparam logic [REG_IDX_WIDTH-1:0] REG_WIN_LEFT   = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_WIN_TOP    = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_WIN_RIGHT  = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_WIN_BOTTOM = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_MASK_MODE  = 3'd4;

    localparam logic [1:0] MASK_NONE = 2'd0;
    localparam logic [1:0] MASK_ZERO = 2'd1;
    localparam logic [1:0] MASK_HIGH = 2'd2;

    localparam logic [7:0]  ALPHA_OPAQUE   = 8'hFF;
    localparam logic [7:0]  MASK_THRESHOLD = 8'd127;
    localparam logic [31:0] ALPHA_FORCE    = 32'hFF00_0000;
    localparam logic [31:0] RGB_MASK       = 32'h00FF_FFFF;

    typedef enum logic [2:0] {
        OUT_BLENDED     = 3'd0,
        OUT_OPAQUE      = 3'd1,
        OUT_CLIPPED     = 3'd2,
        OUT_MASKED      = 3'd3,
        OUT_TRANSPARENT = 3'd4
    } outcome_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pix_x;
        logic signed [COORD_WIDTH-1:0] pix_y;
        logic [31:0]                   src_argb;
        logic [31:0]                   dst_pixel;
        logic [7:0]                    mask_alpha;
    } in_item_t;

    typedef struct packed {
        logic        write_enable;
        logic [31:0] new_pixel;
        outcome_t    outcome;
    } out_item_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] win_left;
        logic [COORD_WIDTH-1:0] win_top;
        logic [COORD_WIDTH-1:0] win_right;
        logic [COORD_WIDTH-1:0] win_bottom;
        logic [1:0]             mask_mode;
    } cfg_t;

endpackage
`default_nettype wire

/* sv/clipped_masked_argb_blend.sv */
// per-pixel raster op: clip window, mask test and source-over blend
// input channel: in_valid / in_stall carry one pixel beat (coordinate, source
// argb, destination pixel, mask alpha); output channel: out_valid / out_stall
// carry one result beat per pixel (write enable, new pixel, outcome code)
// every input beat yields exactly one result beat, in order
// the input register holds each accepted beat, then the blend logic feeds the
// result register that drives out_valid
// throughput: one pixel per clock while out_stall is low (single blend stage)
// a stalled result holds in the result register while the input register
// keeps the next pixel; in_stall rises only when both stages are full and
// the receiver stalls
// configuration goes through the apb port (clip left/top/right/bottom, mask
// mode at byte offsets 0, 4, 8, 12, 16); write it only while no pixel is in
// flight
// reset: pipeline empties, clip window opens to 0..2048 on both axes and the
// mask test is off
`default_nettype none
module clipped_masked_argb_blend
    import cmab_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_item_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_item_t                   out_data,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_WIDTH-1:0] paddr,
    input  wire logic [PDATA_WIDTH-1:0] pwdata,
    output logic      [PDATA_WIDTH-1:0] prdata,
    output logic                        pready
);

    cfg_t      cfg;
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      out_advance;
    logic      s1_advance;

    cmab_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cmab_rop u_rop (
        .item   (s1_item_reg),
        .cfg    (cfg),
        .result (out_item_next)
    );

    assign out_advance = !out_valid_reg || !out_stall;
    assign s1_advance  = !s1_valid_reg || out_advance;
    assign in_stall    = !s1_advance;
    assign out_valid   = out_valid_reg;
    assign out_data    = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && in_valid)
        begin
            s1_item_reg <= in_data;
        end
        if (out_advance && s1_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule
`default_nettype wire

/* sv/cmab_cfg_regs.sv */
`default_nettype none
module cmab_cfg_regs
    import cmab_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_WIDTH-1:0] paddr,
    input  wire logic [PDATA_WIDTH-1:0] pwdata,
    output logic      [PDATA_WIDTH-1:0] prdata,
    output logic                        pready,
    output cfg_t                        cfg
);

    cfg_t                     cfg_reg;
    cfg_t                     cfg_next;
    logic [REG_IDX_WIDTH-1:0] reg_idx;
    logic                     wr_en;

    assign reg_idx = paddr[PADDR_WIDTH-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_WIN_LEFT:   cfg_next.win_left   = pwdata[COORD_WIDTH-1:0];
                REG_WIN_TOP:    cfg_next.win_top    = pwdata[COORD_WIDTH-1:0];
                REG_WIN_RIGHT:  cfg_next.win_right  = pwdata[COORD_WIDTH-1:0];
                REG_WIN_BOTTOM: cfg_next.win_bottom = pwdata[COORD_WIDTH-1:0];
                REG_MASK_MODE:  cfg_next.mask_mode  = pwdata[1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_left   <= '0;
            cfg_reg.win_top    <= '0;
            cfg_reg.win_right  <= CLIP_RB_RESET;
            cfg_reg.win_bottom <= CLIP_RB_RESET;
            cfg_reg.mask_mode  <= MASK_NONE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WIN_LEFT:   prdata = PDATA_WIDTH'(cfg_reg.win_left);
            REG_WIN_TOP:    prdata = PDATA_WIDTH'(cfg_reg.win_top);
            REG_WIN_RIGHT:  prdata = PDATA_WIDTH'(cfg_reg.win_right);
            REG_WIN_BOTTOM: prdata = PDATA_WIDTH'(cfg_reg.win_bottom);
            REG_MASK_MODE:  prdata = PDATA_WIDTH'(cfg_reg.mask_mode);
            default:        prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* sv/cmab_rop.sv */
`default_nettype none
module cmab_rop
    import cmab_pkg::*;
(
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output out_item_t     result
);

    // s*a + d*(255-a) fits 16 bits; floor(v/255) = (v + 1 + (v >> 8)) >> 8 there
    function automatic logic [7:0] mix_channel(input logic [7:0] s, input logic [7:0] d,
                                               input logic [7:0] a);
        logic [15:0] sum;
        logic [16:0] adj;
        sum = 16'(s) * 16'(a) + 16'(d) * 16'(ALPHA_OPAQUE - a);
        adj = 17'(sum) + 17'd1 + 17'(sum[15:8]);
        return adj[15:8];
    endfunction

    logic signed [COORD_WIDTH:0] x_ext;
    logic signed [COORD_WIDTH:0] y_ext;
    logic                        clipped;
    logic                        masked;
    logic [7:0]                  alpha;
    logic [7:0]                  red;
    logic [7:0]                  green;
    logic [7:0]                  blue;

    assign x_ext = {item.pix_x[COORD_WIDTH-1], item.pix_x};
    assign y_ext = {item.pix_y[COORD_WIDTH-1], item.pix_y};

    // clip registers are unsigned, so zero-extend before the signed compare
    assign clipped = (x_ext <  signed'({1'b0, cfg.win_left}))  ||
                     (y_ext <  signed'({1'b0, cfg.win_top}))   ||
                     (x_ext >= signed'({1'b0, cfg.win_right})) ||
                     (y_ext >= signed'({1'b0, cfg.win_bottom}));

    assign masked = ((cfg.mask_mode == MASK_ZERO) && (item.mask_alpha == 8'd0)) ||
                    ((cfg.mask_mode == MASK_HIGH) && (item.mask_alpha > MASK_THRESHOLD));

    assign alpha = item.src_argb[31:24];
    assign red   = mix_channel(item.src_argb[23:16], item.dst_pixel[23:16], alpha);
    assign green = mix_channel(item.src_argb[15:8],  item.dst_pixel[15:8],  alpha);
    assign blue  = mix_channel(item.src_argb[7:0],   item.dst_pixel[7:0],   alpha);

    always_comb
    begin
        result.write_enable = 1'b0;
        result.new_pixel    = '0;
        priority if (clipped)
        begin
            result.outcome = OUT_CLIPPED;
        end
        else if (masked)
        begin
            result.outcome = OUT_MASKED;
        end
        else if (alpha == 8'd0)
        begin
            result.outcome = OUT_TRANSPARENT;
        end
        else if (alpha == ALPHA_OPAQUE)
        begin
            result.write_enable = 1'b1;
            result.new_pixel    = (item.src_argb & RGB_MASK) | ALPHA_FORCE;
            result.outcome      = OUT_OPAQUE;
        end
        else
        begin
            result.write_enable = 1'b1;
            result.new_pixel    = ALPHA_FORCE | {8'd0, red, green, blue};
            result.outcome      = OUT_BLENDED;
        end
    end

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
module tb_top
    import cmab_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MASK_UNUSED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         RANDOM_PHASES  = 10;
    localparam int         PHASE_PIXELS   = 120;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_WIDTH-1:0] paddr = '0;
    logic [PDATA_WIDTH-1:0] pwdata = '0;
    logic [PDATA_WIDTH-1:0] prdata;
    logic                   pready;

    cfg_t      cfg_shadow;
    in_item_t  pixel_feed_q[$];
    out_item_t blend_expect_q[$];
    out_item_t want;
    bit        idle_on = 1'b1;
    int        pixels_fed;
    int        pixels_taken;
    int        results_checked;
    int        fail_cnt;
    int        settings_cnt;
    int        in_gap;
    int        out_gap;
    int        quiet_cycles;

    clipped_masked_argb_blend DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // clip, then mask test, then alpha
    function automatic out_item_t blend_predict(in_item_t p, cfg_t c);
        out_item_t r;
        int        x;
        int        y;
        int        a;
        int        s;
        int        d;
        r = '0;
        x = $signed(p.pix_x);
        y = $signed(p.pix_y);
        a = p.src_argb[31:24];
        if (x < int'(c.win_left) || y < int'(c.win_top) ||
            x >= int'(c.win_right) || y >= int'(c.win_bottom))
        begin
            r.outcome = OUT_CLIPPED;
        end
        else if ((c.mask_mode == MASK_ZERO && p.mask_alpha == 8'd0) ||
                 (c.mask_mode == MASK_HIGH && p.mask_alpha > MASK_THRESHOLD))
        begin
            r.outcome = OUT_MASKED;
        end
        else if (a == 0)
        begin
            r.outcome = OUT_TRANSPARENT;
        end
        else if (a == int'(ALPHA_OPAQUE))
        begin
            r.write_enable = 1'b1;
            r.new_pixel    = (p.src_argb & RGB_MASK) | ALPHA_FORCE;
            r.outcome      = OUT_OPAQUE;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                s = p.src_argb[8*i +: 8];
                d = p.dst_pixel[8*i +: 8];
                r.new_pixel[8*i +: 8] = 8'((s * a + d * (255 - a)) / 255);
            end
            r.new_pixel[31:24] = ALPHA_OPAQUE;
            r.write_enable     = 1'b1;
            r.outcome          = OUT_BLENDED;
        end
        return r;
    endfunction

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                blend_expect_q.push_back(blend_predict(in_data, cfg_shadow));
                pixels_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pixel_feed_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pixel_feed_q.pop_front();
                    if (idle_on && $urandom_range(0, 9) == 0)
                        in_gap = $urandom_range(1, 16);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (blend_expect_q.size() == 0)
                begin
                    $error("result beat with no pixel pending");
                    fail_cnt++;
                end
                else
                begin
                    want = blend_expect_q.pop_front();
                    if (out_data.write_enable !== want.write_enable)
                    begin
                        $error("write_enable expected %0b actual %0b",
                               want.write_enable, out_data.write_enable);
                        fail_cnt++;
                    end
                    if (out_data.new_pixel !== want.new_pixel)
                    begin
                        $error("new_pixel expected %08h actual %08h",
                               want.new_pixel, out_data.new_pixel);
                        fail_cnt++;
                    end
                    if (out_data.outcome !== want.outcome)
                    begin
                        $error("outcome expected %0d actual %0d",
                               want.outcome, out_data.outcome);
                        fail_cnt++;
                    end
                end
                results_checked++;
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (idle_on && $urandom_range(0, 11) == 0)
                    out_gap = $urandom_range(1, 16);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [REG_IDX_WIDTH-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // sender holds off until every result is back, then the pipe settles
    task automatic wait_pipe_empty();
        while (pixel_feed_q.size() != 0 || results_checked < pixels_fed || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int cl, input int ct, input int cr, input int cb,
                              input logic [1:0] mm);
        logic [31:0] wd;
        wait_pipe_empty();
        // upper data bits are junk, only the register width counts
        wd = $urandom();
        wd[11:0] = cl[11:0];
        reg_write(REG_WIN_LEFT, wd);
        wd = $urandom();
        wd[11:0] = ct[11:0];
        reg_write(REG_WIN_TOP, wd);
        wd = $urandom();
        wd[11:0] = cr[11:0];
        reg_write(REG_WIN_RIGHT, wd);
        wd = $urandom();
        wd[11:0] = cb[11:0];
        reg_write(REG_WIN_BOTTOM, wd);
        wd = $urandom();
        wd[1:0] = mm;
        reg_write(REG_MASK_MODE, wd);
        cfg_shadow.win_left   = cl[11:0];
        cfg_shadow.win_top    = ct[11:0];
        cfg_shadow.win_right  = cr[11:0];
        cfg_shadow.win_bottom = cb[11:0];
        cfg_shadow.mask_mode  = mm;
        settings_cnt++;
    endtask

    task automatic push_pixel(input int x, input int y, input logic [31:0] src,
                              input logic [31:0] dst, input logic [7:0] m);
        in_item_t p;
        p.pix_x      = x[COORD_WIDTH-1:0];
        p.pix_y      = y[COORD_WIDTH-1:0];
        p.src_argb   = src;
        p.dst_pixel  = dst;
        p.mask_alpha = m;
        pixel_feed_q.push_back(p);
        pixels_fed++;
    endtask

    // mostly inside or on the edge of the window, sometimes anywhere
    function automatic int pick_coord(logic [11:0] lo, logic [11:0] hi);
        int l;
        int h;
        int v;
        l = lo;
        h = hi;
        case ($urandom_range(0, 9))
            0, 1, 2: v = int'($urandom_range(0, 4095)) - 2048;
            3:       v = l - 1 + int'($urandom_range(0, 1));
            4:       v = h - 1 + int'($urandom_range(0, 1));
            default:
                if (h > l)
                    v = l + int'($urandom_range(0, h - l - 1));
                else
                    v = int'($urandom_range(0, 4095)) - 2048;
        endcase
        if (v < -2048 || v > 2047)
            v = int'($urandom_range(0, 4095)) - 2048;
        return v;
    endfunction

    task automatic push_random_pixel();
        logic [7:0]  a;
        logic [7:0]  m;
        logic [31:0] src;
        case ($urandom_range(0, 9))
            0, 1:    a = 8'd0;
            2, 3:    a = ALPHA_OPAQUE;
            4:       a = ($urandom_range(0, 1) != 0) ? 8'd1 : 8'd254;
            default: a = 8'($urandom());
        endcase
        case ($urandom_range(0, 7))
            0:       m = 8'd0;
            1:       m = MASK_THRESHOLD;
            2:       m = MASK_THRESHOLD + 8'd1;
            3:       m = 8'hFF;
            default: m = 8'($urandom());
        endcase
        src = $urandom();
        src[31:24] = a;
        push_pixel(pick_coord(cfg_shadow.win_left, cfg_shadow.win_right),
                   pick_coord(cfg_shadow.win_top, cfg_shadow.win_bottom),
                   src, $urandom(), m);
    endtask

    initial
    begin
        int cl;
        int ct;
        int cr;
        int cb;
        cfg_shadow.win_left   = '0;
        cfg_shadow.win_top    = '0;
        cfg_shadow.win_right  = CLIP_RB_RESET;
        cfg_shadow.win_bottom = CLIP_RB_RESET;
        cfg_shadow.mask_mode  = MASK_NONE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window, no mask
        push_pixel(-2048, -2048, 32'hFF12_3456, 32'h0000_0000, 8'd0);
        push_pixel(2047, 2047, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0);
        push_pixel(0, 0, 32'h80FF_FFFF, 32'h0000_0000, 8'd0);
        push_pixel(0, 2047, 32'h0100_0000, 32'hFFFF_FFFF, 8'hFF);
        push_pixel(1000, 5, 32'hFEFF_FFFF, 32'hFF00_0000, 8'd0);
        push_pixel(-1, 0, 32'hFFAB_CDEF, 32'h1234_5678, 8'd10);
        push_pixel(5, 5, 32'h00AB_CDEF, 32'h1234_5678, 8'd10);
        push_pixel(7, 9, 32'h7FFF_FFFF, 32'h00FF_FFFF, 8'hFF);

        set_config(100, 50, 200, 150, MASK_ZERO);
        push_pixel(99, 50, 32'hFF11_2233, 32'h4455_6677, 8'd1);
        push_pixel(100, 50, 32'h8011_2233, 32'h4455_6677, 8'd1);
        push_pixel(199, 149, 32'hFF11_2233, 32'h4455_6677, 8'd1);
        push_pixel(200, 149, 32'hFF11_2233, 32'h4455_6677, 8'd1);
        push_pixel(150, 150, 32'hFF11_2233, 32'h4455_6677, 8'd1);
        push_pixel(150, 100, 32'hFF11_2233, 32'h4455_6677, 8'd0);
        // masked wins over transparent, clipped wins over masked
        push_pixel(150, 100, 32'h0011_2233, 32'h4455_6677, 8'd0);
        push_pixel(99, 100, 32'h0011_2233, 32'h4455_6677, 8'd0);
        push_pixel(150, 100, 32'h0011_2233, 32'h4455_6677, 8'hFF);

        set_config(0, 0, 2048, 2048, MASK_HIGH);
        push_pixel(3, 3, 32'hC0A0_B0C0, 32'h0102_0304, MASK_THRESHOLD);
        push_pixel(3, 3, 32'hC0A0_B0C0, 32'h0102_0304, MASK_THRESHOLD + 8'd1);
        push_pixel(3, 3, 32'hC0A0_B0C0, 32'h0102_0304, 8'hFF);

        // unused mode acts as no mask
        set_config(0, 0, 2048, 2048, MASK_UNUSED);
        push_pixel(4, 4, 32'h40A0_B0C0, 32'hFFFF_FFFF, 8'd0);
        push_pixel(4, 4, 32'h40A0_B0C0, 32'hFFFF_FFFF, 8'hFF);

        // inverted window clips everything
        set_config(300, 300, 200, 200, MASK_NONE);
        push_pixel(250, 250, 32'hFF00_FF00, 32'h0000_0000, 8'd5);
        push_pixel(0, 0, 32'hFF00_FF00, 32'h0000_0000, 8'd5);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0 || ph == RANDOM_PHASES - 1)
            begin
                cl = 0; ct = 0; cr = 2048; cb = 2048;
            end
            else if (ph == 1)
            begin
                cl = 0; ct = 0; cr = 0; cb = 0;
            end
            else if (ph == 2)
            begin
                cl = 2048; ct = 2048; cr = 2048; cb = 2048;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        cl = $urandom_range(0, 4095); ct = $urandom_range(0, 4095);
                        cr = $urandom_range(0, 4095); cb = $urandom_range(0, 4095);
                    end
                    default:
                    begin
                        cl = $urandom_range(0, 2047); ct = $urandom_range(0, 2047);
                        cr = $urandom_range(cl + 1, 2048); cb = $urandom_range(ct + 1, 2048);
                    end
                endcase
            end
            set_config(cl, ct, cr, cb, 2'($urandom_range(0, 3)));
            if (ph == RANDOM_PHASES - 1)
                idle_on = 1'b0;
            for (int i = 0; i < PHASE_PIXELS; i++)
                push_random_pixel();
        end

        wait_pipe_empty();
        if (blend_expect_q.size() != 0)
        begin
            $error("%0d results never arrived", blend_expect_q.size());
            fail_cnt++;
        end
        $display("run covered %0d pixel beats under %0d window/mask settings",
                 pixels_taken, settings_cnt);
        $display("%0d result beats checked, %0d mismatches", results_checked, fail_cnt);
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
